// File: rtl/tosc_pkg.sv
package tosc_pkg;

	// Table depth; ids wrap onto it
	localparam int ID_COUNT = 256;
	localparam int ID_SPACE = 256;
	localparam int IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

	// Only min(ID_COUNT, ID_SPACE) distinct entries can ever be reached
	localparam int VLD_DEPTH = (ID_COUNT < ID_SPACE) ? ID_COUNT : ID_SPACE;
	localparam int VLD_W = (VLD_DEPTH > 1) ? $clog2(VLD_DEPTH) : 1;

	// Quotient bits kept; anything at or above 2**Q_W is out of range
	localparam int Q_W = 18;
	localparam int CNT_W = $clog2(Q_W);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CONE_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIM = 2'd2;

	localparam logic [7:0] CONE_TYPE_RST = 8'd10;
	localparam logic [14:0] DEV_THR_RST = 15'd1920;
	localparam logic signed [15:0] LOW_LIM_RST = 16'sd1536;

	typedef logic [IDX_W-1:0] idx_t;
	typedef idx_t idx_lut_t [ID_SPACE];

	typedef enum logic [2:0] {
		OUT_CONE = 3'd0,
		OUT_NEW = 3'd1,
		OUT_KEPT = 3'd2,
		OUT_CORRECTED = 3'd3,
		OUT_REPLACED = 3'd4,
		OUT_SAME_TIME = 3'd5
	} outcome_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_SUM,
		S_PREP,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] frame_time;
		logic signed [15:0] chassis;
		logic signed [16:0] pos;
		logic [15:0] age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic idx_lut_t build_idx_lut();
		idx_lut_t lut;
		for (int i = 0; i < ID_SPACE; i++) begin
			lut[i] = IDX_W'(i % ID_COUNT);
		end
		return lut;
	endfunction

	localparam idx_lut_t IDX_LUT = build_idx_lut();

endpackage

// File: rtl/tracked_object_speed_corrector.sv
// Tracked object speed corrector.
// Object channel: obj_valid / obj_stall with id, age, type, position, reported
// speed, frame time and chassis speed. Result channel: res_valid / res_stall
// with speed_out and outcome, one result per object. Config channel:
// cfg_valid / cfg_ready, cfg_index selects cone type (0), deviation threshold
// (1) or low speed limit (2); other indexes are dropped. Write config only
// while the block is idle.
// One object is processed at a time; obj_stall is high from acceptance until
// the result moves into the output register. Per-id state sits in one RAM
// read in the cycle after acceptance and written back in S_READ unless the
// frame time is unchanged. A cone goes straight to S_DONE; a new track, an
// age drop or a zero time step go S_READ then S_DONE; a speed estimate goes
// through S_MUL, S_SUM, S_PREP, the 18-step restoring divider (one quotient
// bit a cycle; skipped when the estimate is out of range), S_FIN, S_DONE.
// The output register frees the core: a stalled result holds while the next
// object can be accepted and processed; that one waits in its final state
// until the output register is taken.
// Reset clears all valid bits of the table (no sweep) and restores the
// configuration defaults.
module tracked_object_speed_corrector
	import tosc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic obj_valid,
	output logic obj_stall,
	input logic [7:0] obj_id,
	input logic [15:0] obj_age,
	input logic [7:0] obj_type,
	input logic signed [16:0] pos_x,
	input logic signed [15:0] speed_x,
	input logic [31:0] frame_time,
	input logic signed [15:0] chassis_speed,
	output logic res_valid,
	input logic res_stall,
	output logic signed [15:0] speed_out,
	output logic [2:0] outcome,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [7:0] cone_type_q;
	logic [14:0] dev_thr_q;
	logic signed [15:0] low_lim_q;

	logic [VLD_DEPTH-1:0] vld_q;

	idx_t idx_q;
	logic [15:0] age_q;
	logic signed [16:0] pos_q;
	logic signed [15:0] spd_q;
	logic [31:0] time_q;
	logic signed [15:0] chas_q;

	logic signed [31:0] dt_q;
	logic signed [17:0] posd_q;
	logic signed [15:0] chas_prev_q;
	logic signed [47:0] prod_q;
	logic signed [28:0] pscl_q;
	logic signed [48:0] num_q;
	logic [48:0] rem_q;
	logic [48:0] dsh_q;
	logic [Q_W-1:0] quo_q;
	logic neg_q;
	logic big_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [15:0] pend_speed_q;
	outcome_t pend_outcome_q;

	logic res_valid_q;
	logic signed [15:0] speed_out_q;
	outcome_t outcome_q;

	logic ram_re, ram_we, out_load;
	entry_t rd_entry, wr_entry;
	logic [ENTRY_W-1:0] rd_data;

	logic hit, older;
	logic signed [31:0] dt_c;
	logic [48:0] num_mag;
	logic [31:0] dt_mag;
	logic big_c;
	logic ge_c;
	logic signed [18:0] est_c;
	logic signed [19:0] diff_c;
	logic [19:0] abs_c;
	logic corr_c;
	logic signed [15:0] sat_c;

	assign wr_entry = '{frame_time: time_q, chassis: chas_q, pos: pos_q, age: age_q};
	assign rd_entry = entry_t'(rd_data);

	tosc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ID_COUNT)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_q),
		.wdata(wr_entry),
		.re(ram_re),
		.raddr(IDX_LUT[obj_id]),
		.rdata(rd_data)
	);

	// Table lookup decision
	assign hit = vld_q[idx_q[VLD_W-1:0]];
	assign older = age_q < rd_entry.age;
	assign dt_c = time_q - rd_entry.frame_time;

	// Divider setup
	assign num_mag = num_q[48] ? 49'(-num_q) : 49'(num_q);
	assign dt_mag = dt_q[31] ? 32'(-dt_q) : 32'(dt_q);
	assign big_c = {1'b0, num_mag} >= {dt_mag, {Q_W{1'b0}}};
	assign ge_c = rem_q >= dsh_q;

	// Final compare and saturation
	assign est_c = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign diff_c = 20'(est_c) - 20'(spd_q);
	assign abs_c = diff_c[19] ? 20'(-diff_c) : 20'(diff_c);
	assign corr_c = (big_q || (abs_c > 20'(dev_thr_q))) && (spd_q < low_lim_q);

	always_comb begin
		if (big_q) begin
			sat_c = neg_q ? -16'sd32768 : 16'sd32767;
		end else if (est_c > 19'sd32767) begin
			sat_c = 16'sd32767;
		end else if (est_c < -19'sd32768) begin
			sat_c = -16'sd32768;
		end else begin
			sat_c = est_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		obj_stall = 1'b1;
		ram_re = 1'b0;
		ram_we = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				obj_stall = 1'b0;
				if (obj_valid) begin
					ram_re = 1'b1;
					state_d = (obj_type == cone_type_q) ? S_DONE : S_READ;
				end
			end
			S_READ: begin
				if (!hit || older) begin
					ram_we = 1'b1;
					state_d = S_DONE;
				end else if (dt_c == '0) begin
					state_d = S_DONE;
				end else begin
					ram_we = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_PREP;
			S_PREP: state_d = big_c ? S_FIN : S_DIV;
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_DONE;
			S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_type_q <= CONE_TYPE_RST;
			dev_thr_q <= DEV_THR_RST;
			low_lim_q <= LOW_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CONE_TYPE: cone_type_q <= cfg_data[7:0];
				CFG_DEV_THR: dev_thr_q <= cfg_data[14:0];
				CFG_LOW_LIM: low_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[idx_q[VLD_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_PREP) begin
			cnt_q <= CNT_W'(Q_W - 1);
		end else if (state_q == S_DIV) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (obj_valid) begin
					idx_q <= IDX_LUT[obj_id];
					age_q <= obj_age;
					pos_q <= pos_x;
					spd_q <= speed_x;
					time_q <= frame_time;
					chas_q <= chassis_speed;
					pend_speed_q <= speed_x;
					pend_outcome_q <= OUT_CONE;
				end
			end
			S_READ: begin
				posd_q <= 18'(pos_q) - 18'(rd_entry.pos);
				chas_prev_q <= rd_entry.chassis;
				dt_q <= dt_c;
				if (!hit) begin
					pend_outcome_q <= OUT_NEW;
				end else if (older) begin
					pend_outcome_q <= OUT_REPLACED;
				end else begin
					pend_outcome_q <= OUT_SAME_TIME;
				end
			end
			S_MUL: begin
				prod_q <= chas_prev_q * dt_q;
				pscl_q <= posd_q * 29'sd1000;
			end
			S_SUM: begin
				num_q <= 49'(prod_q) + 49'(pscl_q);
			end
			S_PREP: begin
				rem_q <= num_mag;
				dsh_q <= {dt_mag, {(Q_W - 1){1'b0}}};
				quo_q <= '0;
				neg_q <= num_q[48] ^ dt_q[31];
				big_q <= big_c;
			end
			S_DIV: begin
				if (ge_c) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[Q_W-2:0], ge_c};
				dsh_q <= dsh_q >> 1;
			end
			S_FIN: begin
				pend_speed_q <= corr_c ? sat_c : spd_q;
				pend_outcome_q <= corr_c ? OUT_CORRECTED : OUT_KEPT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			speed_out_q <= pend_speed_q;
			outcome_q <= pend_outcome_q;
		end
	end

	assign res_valid = res_valid_q;
	assign speed_out = speed_out_q;
	assign outcome = 3'(outcome_q);

endmodule

// File: rtl/tosc_ram.sv
module tosc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/tosc_checker.sv
module tosc_checker
	import tosc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic obj_valid,
	input logic obj_stall,
	input logic [7:0] obj_id,
	input logic [15:0] obj_age,
	input logic [7:0] obj_type,
	input logic signed [16:0] pos_x,
	input logic signed [15:0] speed_x,
	input logic [31:0] frame_time,
	input logic signed [15:0] chassis_speed,
	input logic res_valid,
	input logic res_stall,
	input logic signed [15:0] speed_out,
	input logic [2:0] outcome,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(speed_out) && $stable(outcome))
		else $error("result changed while stalled");

	// One request in flight: stall right after acceptance
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && !obj_stall |=> obj_stall)
		else $error("second request taken while busy");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && !obj_stall |=> !cfg_ready)
		else $error("config open while a request is in flight");

	// A new result only follows a busy cycle
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(obj_stall))
		else $error("result without a request in flight");

endmodule

bind tracked_object_speed_corrector tosc_checker u_tosc_checker (.*);
